// ===== sv/lvlp_pkg.sv =====
package lvlp_pkg;

    // Log geometry
    localparam int NUM_DRVS  = 22;
    localparam int DRV_WORDS = (NUM_DRVS + 3) / 4;
    localparam int WIR_W     = $clog2(DRV_WORDS + 1);

    // Field widths
    localparam int WORD_W  = 32;
    localparam int MASK_W  = 22;
    localparam int BYTE_W  = 8;
    localparam int PER_W   = 16;

    // Queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration
    localparam int PADDR_W            = 3;
    localparam int CLAIM_MIN_RESET    = 3;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR2,
        PH_TS,
        PH_DRV
    } phase_t;

    typedef enum logic [1:0] {
        KIND_RECORD  = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_NOLOG   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TRANS_NONE  = 2'd0,
        TRANS_ENTER = 2'd1,
        TRANS_EXIT  = 2'd2
    } trans_t;

    // What one queued entry expands to
    typedef enum logic [1:0] {
        OP_REC,
        OP_SUM,
        OP_REC_SUM,
        OP_NOLOG
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  ts;
        logic [MASK_W-1:0]  rec_mask;
        trans_t             trans;
        logic [BYTE_W-1:0]  count;
        logic [MASK_W-1:0]  blk;
        logic               ok;
        logic [BYTE_W-1:0]  mode;
        logic [PER_W-1:0]   period;
        logic [BYTE_W-1:0]  flush;
        logic [BYTE_W-1:0]  shift;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== sv/lvlp_front.sv =====
// Word parser: walks the header and records, emits one queue entry per
// word that produces results.
module lvlp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [lvlp_pkg::WORD_W-1:0]     log_word,
    input  logic                            log_start,
    input  logic [lvlp_pkg::BYTE_W-1:0]     claim_min,
    output logic                            push,
    output lvlp_pkg::entry_t                push_entry
);

    lvlp_pkg::phase_t                  phase_reg, phase_next;
    logic [lvlp_pkg::BYTE_W-1:0]       mode_reg, mode_next;
    logic [lvlp_pkg::BYTE_W-1:0]       limit_reg, limit_next;
    logic [lvlp_pkg::PER_W-1:0]        period_reg, period_next;
    logic [lvlp_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [lvlp_pkg::BYTE_W-1:0]       flush_reg, flush_next;
    logic [lvlp_pkg::BYTE_W-1:0]       records_reg, records_next;
    logic [lvlp_pkg::WIR_W-1:0]        wir_reg, wir_next;
    logic [lvlp_pkg::WORD_W-1:0]       ts_reg, ts_next;
    logic [lvlp_pkg::MASK_W-1:0]       cmask_reg, cmask_next;
    logic [lvlp_pkg::MASK_W-1:0]       always_reg, always_next;
    logic                              exit_reg, exit_next;

    logic [lvlp_pkg::MASK_W-1:0]       word_bits;
    logic [lvlp_pkg::MASK_W-1:0]       mask_acc;
    logic [lvlp_pkg::MASK_W-1:0]       always_acc;
    logic [lvlp_pkg::BYTE_W-1:0]       count_inc;
    logic                              rec_done;
    logic                              limit_hit;
    logic                              word_zero;
    logic [lvlp_pkg::WORD_W-1:0]       ts_shifted;
    logic                              sum_ok_now;
    logic                              sum_ok_inc;

    // Nonzero bytes of this DRV word, placed at their DRV positions
    always_comb
    begin
        word_bits = '0;
        for (int j = 0; j < lvlp_pkg::NUM_DRVS; j++)
        begin
            if ((lvlp_pkg::WIR_W'(j / 4) == wir_reg) &&
                (log_word[8*(j%4) +: 8] != 8'h00))
            begin
                word_bits[j] = 1'b1;
            end
        end
    end

    assign mask_acc   = cmask_reg | word_bits;
    assign always_acc = always_reg & mask_acc;
    assign count_inc  = records_reg + 8'd1;
    assign rec_done   = (wir_reg == lvlp_pkg::WIR_W'(lvlp_pkg::DRV_WORDS - 1));
    assign limit_hit  = (count_inc >= limit_reg);
    assign word_zero  = (log_word == '0);
    assign ts_shifted = (shift_reg >= 8'd32) ? '0 : (log_word << shift_reg[4:0]);
    assign sum_ok_now = (records_reg >= claim_min);
    assign sum_ok_inc = (count_inc >= claim_min);

    // Next parse phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (log_start)
            begin
                phase_next = word_zero ? lvlp_pkg::PH_IDLE : lvlp_pkg::PH_HDR2;
            end
            else
            begin
                unique case (phase_reg)
                    lvlp_pkg::PH_IDLE: phase_next = lvlp_pkg::PH_IDLE;
                    lvlp_pkg::PH_HDR2:
                        phase_next = (word_zero || limit_reg == '0) ?
                                     lvlp_pkg::PH_IDLE : lvlp_pkg::PH_TS;
                    lvlp_pkg::PH_TS:
                        phase_next = word_zero ? lvlp_pkg::PH_IDLE : lvlp_pkg::PH_DRV;
                    lvlp_pkg::PH_DRV:
                        if (rec_done)
                        begin
                            phase_next = limit_hit ? lvlp_pkg::PH_IDLE : lvlp_pkg::PH_TS;
                        end
                    default: phase_next = lvlp_pkg::PH_IDLE;
                endcase
            end
        end
    end

    // Datapath updates and queue entry
    always_comb
    begin
        mode_next    = mode_reg;
        limit_next   = limit_reg;
        period_next  = period_reg;
        shift_next   = shift_reg;
        flush_next   = flush_reg;
        records_next = records_reg;
        wir_next     = wir_reg;
        ts_next      = ts_reg;
        cmask_next   = cmask_reg;
        always_next  = always_reg;
        exit_next    = exit_reg;
        push         = 1'b0;
        push_entry   = '0;
        push_entry.mode   = mode_reg;
        push_entry.period = period_reg;
        push_entry.flush  = flush_reg;
        push_entry.shift  = shift_reg;

        if (accept)
        begin
            if (log_start)
            begin
                records_next = '0;
                wir_next     = '0;
                ts_next      = '0;
                cmask_next   = '0;
                always_next  = '1;
                exit_next    = 1'b0;
                if (word_zero)
                begin
                    push       = 1'b1;
                    push_entry = '0;
                    push_entry.op = lvlp_pkg::OP_NOLOG;
                end
                else
                begin
                    mode_next  = log_word[7:0];
                    limit_next = log_word[15:8];
                end
            end
            else
            begin
                unique case (phase_reg)
                    lvlp_pkg::PH_IDLE:
                    begin
                    end
                    lvlp_pkg::PH_HDR2:
                    begin
                        if (word_zero || limit_reg == '0)
                        begin
                            push       = 1'b1;
                            push_entry = '0;
                            push_entry.op = lvlp_pkg::OP_NOLOG;
                        end
                        if (!word_zero)
                        begin
                            period_next = log_word[15:0];
                            shift_next  = log_word[23:16];
                            flush_next  = log_word[31:24];
                        end
                    end
                    lvlp_pkg::PH_TS:
                    begin
                        if (word_zero)
                        begin
                            push             = 1'b1;
                            push_entry.op    = lvlp_pkg::OP_SUM;
                            push_entry.count = records_reg;
                            push_entry.ok    = sum_ok_now;
                            push_entry.blk   = sum_ok_now ? always_reg : '0;
                        end
                        else
                        begin
                            ts_next    = ts_shifted;
                            cmask_next = '0;
                            wir_next   = '0;
                        end
                    end
                    lvlp_pkg::PH_DRV:
                    begin
                        cmask_next = mask_acc;
                        wir_next   = wir_reg + 1'b1;
                        if (rec_done)
                        begin
                            wir_next     = '0;
                            always_next  = always_acc;
                            records_next = count_inc;
                            push         = 1'b1;
                            push_entry.op       = limit_hit ? lvlp_pkg::OP_REC_SUM :
                                                              lvlp_pkg::OP_REC;
                            push_entry.ts       = ts_reg;
                            push_entry.rec_mask = mask_acc;
                            push_entry.trans    = lvlp_pkg::TRANS_NONE;
                            if (mask_acc == '0)
                            begin
                                push_entry.trans = exit_reg ? lvlp_pkg::TRANS_EXIT :
                                                              lvlp_pkg::TRANS_ENTER;
                                exit_next        = ~exit_reg;
                            end
                            push_entry.count = count_inc;
                            push_entry.ok    = sum_ok_inc;
                            push_entry.blk   = sum_ok_inc ? always_acc : '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lvlp_pkg::PH_IDLE;
            records_reg <= '0;
            wir_reg     <= '0;
            always_reg  <= '1;
            exit_reg    <= 1'b0;
            limit_reg   <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            records_reg <= records_next;
            wir_reg     <= wir_next;
            always_reg  <= always_next;
            exit_reg    <= exit_next;
            limit_reg   <= limit_next;
        end
    end

    // Header and record payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= '0;
            period_reg <= '0;
            shift_reg  <= '0;
            flush_reg  <= '0;
            ts_reg     <= '0;
            cmask_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            period_reg <= period_next;
            shift_reg  <= shift_next;
            flush_reg  <= flush_next;
            ts_reg     <= ts_next;
            cmask_reg  <= cmask_next;
        end
    end

endmodule

// ===== sv/lvlp_queue.sv =====
// Small queue of parsed entries between parser and output stage.
module lvlp_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lvlp_pkg::entry_t      push_entry,
    input  logic                  pop,
    output lvlp_pkg::entry_t      head,
    output lvlp_pkg::qstat_t      stat
);

    lvlp_pkg::entry_t                 mem [lvlp_pkg::QUEUE_DEPTH];
    logic [lvlp_pkg::QPTR_W-1:0]      wptr_reg, wptr_next;
    logic [lvlp_pkg::QPTR_W-1:0]      rptr_reg, rptr_next;
    logic [lvlp_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign stat.full  = (count_reg == lvlp_pkg::QCNT_W'(lvlp_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rptr_reg];

    // Pointer and fill updates
    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_entry;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.full |-> !push || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        stat.empty |-> !pop)
        else $error("queue read while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && !stat.full) |=> !stat.empty)
        else $error("queue lost an entry");

endmodule

// ===== sv/lvlp_back.sv =====
// Output stage: expands queue entries into results, one per transfer.
module lvlp_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lvlp_pkg::entry_t                 head,
    input  lvlp_pkg::qstat_t                 stat,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       result_kind,
    output logic [lvlp_pkg::WORD_W-1:0]      record_timestamp,
    output logic [lvlp_pkg::MASK_W-1:0]      record_nonzero_mask,
    output logic [1:0]                       transition,
    output logic [lvlp_pkg::BYTE_W-1:0]      record_count,
    output logic [lvlp_pkg::MASK_W-1:0]      blocker_mask,
    output logic                             claim_ok,
    output logic [lvlp_pkg::BYTE_W-1:0]      mode_type,
    output logic [lvlp_pkg::PER_W-1:0]       sample_period_ms,
    output logic [lvlp_pkg::BYTE_W-1:0]      samples_per_record,
    output logic [lvlp_pkg::BYTE_W-1:0]      timestamp_shift,
    output logic                             last
);

    logic                            valid_reg, valid_next;
    logic                            second_reg, second_next;
    logic                            load;
    logic                            emit_sum;
    lvlp_pkg::kind_t                 kind_sel;

    lvlp_pkg::kind_t                 kind_reg;
    logic [lvlp_pkg::WORD_W-1:0]     ts_reg;
    logic [lvlp_pkg::MASK_W-1:0]     mask_reg;
    lvlp_pkg::trans_t                trans_reg;
    logic [lvlp_pkg::BYTE_W-1:0]     count_reg;
    logic [lvlp_pkg::MASK_W-1:0]     blk_reg;
    logic                            ok_reg;
    logic [lvlp_pkg::BYTE_W-1:0]     mode_reg;
    logic [lvlp_pkg::PER_W-1:0]      period_reg;
    logic [lvlp_pkg::BYTE_W-1:0]     flush_reg;
    logic [lvlp_pkg::BYTE_W-1:0]     shift_reg;
    logic                            last_reg;

    // Output register is free when empty or its result is being taken
    assign load = !valid_reg || out_ready;

    // Sequencing of one- and two-result entries
    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        pop         = 1'b0;
        emit_sum    = 1'b0;
        kind_sel    = lvlp_pkg::KIND_RECORD;
        if (load)
        begin
            valid_next = !stat.empty;
            if (!stat.empty)
            begin
                unique case (head.op)
                    lvlp_pkg::OP_REC:
                    begin
                        pop = 1'b1;
                    end
                    lvlp_pkg::OP_SUM:
                    begin
                        pop      = 1'b1;
                        emit_sum = 1'b1;
                        kind_sel = lvlp_pkg::KIND_SUMMARY;
                    end
                    lvlp_pkg::OP_REC_SUM:
                    begin
                        if (second_reg)
                        begin
                            pop         = 1'b1;
                            emit_sum    = 1'b1;
                            kind_sel    = lvlp_pkg::KIND_SUMMARY;
                            second_next = 1'b0;
                        end
                        else
                        begin
                            second_next = 1'b1;
                        end
                    end
                    lvlp_pkg::OP_NOLOG:
                    begin
                        pop      = 1'b1;
                        kind_sel = lvlp_pkg::KIND_NOLOG;
                    end
                    default:
                    begin
                        pop = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (load && !stat.empty)
        begin
            kind_reg   <= kind_sel;
            mode_reg   <= head.mode;
            period_reg <= head.period;
            flush_reg  <= head.flush;
            shift_reg  <= head.shift;
            if (kind_sel == lvlp_pkg::KIND_RECORD)
            begin
                ts_reg    <= head.ts;
                mask_reg  <= head.rec_mask;
                trans_reg <= head.trans;
                count_reg <= '0;
                blk_reg   <= '0;
                ok_reg    <= 1'b0;
                last_reg  <= 1'b0;
            end
            else
            begin
                ts_reg    <= '0;
                mask_reg  <= '0;
                trans_reg <= lvlp_pkg::TRANS_NONE;
                count_reg <= emit_sum ? head.count : '0;
                blk_reg   <= emit_sum ? head.blk : '0;
                ok_reg    <= emit_sum ? head.ok : 1'b0;
                last_reg  <= 1'b1;
            end
        end
    end

    assign out_valid           = valid_reg;
    assign result_kind         = kind_reg;
    assign record_timestamp    = ts_reg;
    assign record_nonzero_mask = mask_reg;
    assign transition          = trans_reg;
    assign record_count        = count_reg;
    assign blocker_mask        = blk_reg;
    assign claim_ok            = ok_reg;
    assign mode_type           = mode_reg;
    assign sample_period_ms    = period_reg;
    assign samples_per_record  = flush_reg;
    assign timestamp_shift     = shift_reg;
    assign last                = last_reg;

endmodule

// ===== sv/lpm_violator_log_parser.sv =====
// A word that produces results enters the queue at its transfer edge; its first result
//   is loaded into the output register once its entry heads the queue and the register is free.
// Throughput: one log word per cycle while the queue has room; a record reaching
//   the limit yields a record and a summary that hold the output register in turn.
// Reset: rst_n (async, active low) puts the parser idle, empties the queue and
//   output stage, and sets claim_min_records to 3.
module lpm_violator_log_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lvlp_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lvlp_pkg::WORD_W-1:0]         log_word,
    input  logic                                log_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          result_kind,
    output logic [lvlp_pkg::WORD_W-1:0]         record_timestamp,
    output logic [lvlp_pkg::MASK_W-1:0]         record_nonzero_mask,
    output logic [1:0]                          transition,
    output logic [lvlp_pkg::BYTE_W-1:0]         record_count,
    output logic [lvlp_pkg::MASK_W-1:0]         blocker_mask,
    output logic                                claim_ok,
    output logic [lvlp_pkg::BYTE_W-1:0]         mode_type,
    output logic [lvlp_pkg::PER_W-1:0]          sample_period_ms,
    output logic [lvlp_pkg::BYTE_W-1:0]         samples_per_record,
    output logic [lvlp_pkg::BYTE_W-1:0]         timestamp_shift,
    output logic                                last
);

    logic [lvlp_pkg::BYTE_W-1:0]  claim_min_reg, claim_min_next;
    logic                         claim_sel;
    logic                         accept;
    logic                         push;
    logic                         pop;
    lvlp_pkg::entry_t             push_entry;
    lvlp_pkg::entry_t             head;
    lvlp_pkg::qstat_t             stat;

    // Register file: claim_min_records at byte address 0
    assign pready    = 1'b1;
    assign claim_sel = (paddr[2] == 1'b0);
    assign prdata    = claim_sel ? {24'h0, claim_min_reg} : 32'h0;

    always_comb
    begin
        claim_min_next = claim_min_reg;
        if (psel && penable && pwrite && claim_sel)
        begin
            claim_min_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claim_min_reg <= lvlp_pkg::BYTE_W'(lvlp_pkg::CLAIM_MIN_RESET);
        end
        else
        begin
            claim_min_reg <= claim_min_next;
        end
    end

    // Input transfer whenever the queue has room
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    lvlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .log_word   (log_word),
        .log_start  (log_start),
        .claim_min  (claim_min_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    lvlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    lvlp_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head                (head),
        .stat                (stat),
        .pop                 (pop),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .result_kind         (result_kind),
        .record_timestamp    (record_timestamp),
        .record_nonzero_mask (record_nonzero_mask),
        .transition          (transition),
        .record_count        (record_count),
        .blocker_mask        (blocker_mask),
        .claim_ok            (claim_ok),
        .mode_type           (mode_type),
        .sample_period_ms    (sample_period_ms),
        .samples_per_record  (samples_per_record),
        .timestamp_shift     (timestamp_shift),
        .last                (last)
    );

endmodule
